// ----- rtl/zigzag_array_count_assert.svh -----
// Assertion macros shared by the checker files of the zig-zag array counter.
// Depends on nothing; each macro expands to one labeled concurrent assertion.
`ifndef ZIGZAG_ARRAY_COUNT_ASSERT_SVH
`define ZIGZAG_ARRAY_COUNT_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock, off while in reset.
`define ZAC_ASSERT_SAME(lbl, clk_s, rstn_s, ante, cons) \
    lbl: assert property (@(posedge clk_s) disable iff (!(rstn_s)) (ante) |-> (cons)) \
        else $error("zigzag_array_count check failed");

// Next-cycle implication, sampled on the rising clock, off while in reset.
`define ZAC_ASSERT_NEXT(lbl, clk_s, rstn_s, ante, cons) \
    lbl: assert property (@(posedge clk_s) disable iff (!(rstn_s)) (ante) |=> (cons)) \
        else $error("zigzag_array_count check failed");

`endif

// ----- rtl/zac_pkg.sv -----
// Shared types, constants and modular helpers for the zig-zag array counter.
// Used by the controller, the datapath and the port checker.
package zac_pkg;

    localparam logic [29:0]     ZAC_PRIME = 30'd1000000007;

    // Pass selector carried from controller to datapath.
    typedef enum logic [1:0] {
        OP_FILL = 2'd0,
        OP_SUM  = 2'd1,
        OP_UPD  = 2'd2,
        OP_TOT  = 2'd3
    } op_t;

    // Commands from the controller.
    typedef struct packed {
        logic load;
        logic issue;
        op_t  op;
        logic dec_round;
        logic finish;
    } cmd_t;

    // Status back to the controller.
    typedef struct packed {
        logic last;
        logic rounds_zero;
        logic round_last;
        logic error;
    } sts_t;

    // Sum of two residues, reduced once.
    function automatic logic [29:0] add_mod(input logic [29:0] a, input logic [29:0] b);
        logic [30:0] s;
        s = {1'b0, a} + {1'b0, b};
        add_mod = (s >= {1'b0, ZAC_PRIME}) ? 30'(s - {1'b0, ZAC_PRIME}) : s[29:0];
    endfunction

    // Difference of two residues, wrapped back into range.
    function automatic logic [29:0] sub_mod(input logic [29:0] a, input logic [29:0] b);
        logic [30:0] s;
        s = {1'b0, a} + {1'b0, ZAC_PRIME} - {1'b0, b};
        sub_mod = (a >= b) ? (a - b) : s[29:0];
    endfunction

endpackage

// ----- rtl/zac_ctrl.sv -----
// Sequencer for the zig-zag array counter: walks fill, round and total passes.
// Depends on zac_pkg; drives the datapath through cmd_t and reads sts_t.
module zac_ctrl
    import zac_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    output logic out_valid,
    input  logic out_ready,
    output cmd_t cmd,
    input  sts_t sts
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_FILL  = 4'd1;
    localparam logic [3:0] S_SUM   = 4'd2;
    localparam logic [3:0] S_SUM_W = 4'd3;
    localparam logic [3:0] S_UPD   = 4'd4;
    localparam logic [3:0] S_UPD_W = 4'd5;
    localparam logic [3:0] S_TOT   = 4'd6;
    localparam logic [3:0] S_TOT_W = 4'd7;
    localparam logic [3:0] S_FIN   = 4'd8;

    logic [3:0] state_reg, state_next;
    logic       out_valid_reg, out_valid_next;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

    // Next state and command decode.
    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd            = '0;
        cmd.op         = OP_FILL;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_FILL;
                end
            end
            S_FILL:
            begin
                if (sts.error)
                begin
                    state_next = S_FIN;
                end
                else
                begin
                    cmd.issue = 1'b1;
                    cmd.op    = OP_FILL;
                    if (sts.last)
                    begin
                        state_next = sts.rounds_zero ? S_TOT : S_SUM;
                    end
                end
            end
            S_SUM:
            begin
                cmd.issue = 1'b1;
                cmd.op    = OP_SUM;
                if (sts.last)
                begin
                    state_next = S_SUM_W;
                end
            end
            S_SUM_W:
            begin
                state_next = S_UPD;
            end
            S_UPD:
            begin
                cmd.issue = 1'b1;
                cmd.op    = OP_UPD;
                if (sts.last)
                begin
                    state_next = S_UPD_W;
                end
            end
            S_UPD_W:
            begin
                cmd.dec_round = 1'b1;
                state_next    = sts.round_last ? S_TOT : S_SUM;
            end
            S_TOT:
            begin
                cmd.issue = 1'b1;
                cmd.op    = OP_TOT;
                if (sts.last)
                begin
                    state_next = S_TOT_W;
                end
            end
            S_TOT_W:
            begin
                state_next = S_FIN;
            end
            S_FIN:
            begin
                // Wait until the output register is free.
                if (!out_valid_reg || out_ready)
                begin
                    cmd.finish     = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State and output handshake registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// ----- rtl/zac_datapath.sv -----
// Datapath of the zig-zag array counter: request registers, the two count
// tables, the prefix accumulators and the result register. Depends on zac_pkg.
module zac_datapath
    import zac_pkg::*;
#(
    parameter int unsigned MAX_RANGE = 2048
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic [12:0] array_length,
    input  logic [15:0] range_low,
    input  logic [15:0] range_high,
    input  cmd_t        cmd,
    output sts_t        sts,
    output logic [29:0] count,
    output logic        range_error
);

    localparam int unsigned AW = (MAX_RANGE > 1) ? $clog2(MAX_RANGE) : 1;

    // Count tables, indexed by element value minus range_low.
    logic [29:0] desc_mem [MAX_RANGE];
    logic [29:0] asc_mem  [MAX_RANGE];

    logic [AW-1:0] last_idx_reg;
    logic          err_reg;
    logic [12:0]   rounds_reg;
    logic [AW-1:0] idx_reg;
    logic          rd_valid_reg;
    logic          rd_first_reg;
    op_t           rd_op_reg;
    logic [AW-1:0] rd_idx_reg;
    logic [29:0]   desc_q_reg, asc_q_reg;
    logic [29:0]   total_reg, total_next;
    logic [29:0]   run0_reg, run0_next;
    logic [29:0]   run1_reg, run1_next;
    logic [29:0]   count_reg;
    logic          range_error_reg;

    logic [16:0]   span;
    logic          req_err;
    logic          rd_en;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [29:0]   wr_desc, wr_asc;
    logic [29:0]   r0, r1, p1;

    // Range check on the incoming request.
    assign span    = {1'b0, range_high} - {1'b0, range_low};
    assign req_err = (range_low > range_high) || ({15'd0, span} >= 32'(MAX_RANGE));

    assign sts.last        = (idx_reg == last_idx_reg);
    assign sts.rounds_zero = (rounds_reg == 13'd0);
    assign sts.round_last  = (rounds_reg == 13'd1);
    assign sts.error       = err_reg;

    assign count       = count_reg;
    assign range_error = range_error_reg;

    assign rd_en = cmd.issue && (cmd.op != OP_FILL);

    // Element processing in the cycle after the table read.
    always_comb
    begin
        r0         = rd_first_reg ? 30'd0 : run0_reg;
        r1         = rd_first_reg ? 30'd0 : run1_reg;
        p1         = add_mod(r1, asc_q_reg);
        total_next = total_reg;
        run0_next  = run0_reg;
        run1_next  = run1_reg;
        wr_en      = 1'b0;
        wr_addr    = idx_reg;
        wr_desc    = 30'd1;
        wr_asc     = 30'd1;
        if (cmd.issue && (cmd.op == OP_FILL))
        begin
            wr_en = 1'b1;
        end
        if (rd_valid_reg)
        begin
            unique case (rd_op_reg)
                OP_SUM:
                begin
                    total_next = add_mod(rd_first_reg ? 30'd0 : total_reg, asc_q_reg);
                end
                OP_UPD:
                begin
                    // New descending: ascending counts strictly above this value.
                    wr_en     = 1'b1;
                    wr_addr   = rd_idx_reg;
                    wr_asc    = r0;
                    wr_desc   = sub_mod(total_reg, p1);
                    run1_next = p1;
                    run0_next = add_mod(r0, desc_q_reg);
                end
                OP_TOT:
                begin
                    run0_next = add_mod(r0, desc_q_reg);
                    run1_next = p1;
                end
                default:
                begin
                    total_next = total_reg;
                end
            endcase
        end
    end

    // Table write and registered read.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            desc_mem[wr_addr] <= wr_desc;
            asc_mem[wr_addr]  <= wr_asc;
        end
        if (rd_en)
        begin
            desc_q_reg <= desc_mem[idx_reg];
            asc_q_reg  <= asc_mem[idx_reg];
        end
    end

    // Accumulators and request payload.
    always_ff @(posedge clk)
    begin
        total_reg  <= total_next;
        run0_reg   <= run0_next;
        run1_reg   <= run1_next;
        rd_idx_reg <= idx_reg;
        rd_op_reg  <= cmd.op;
        if (cmd.load)
        begin
            last_idx_reg <= span[AW-1:0];
        end
        if (cmd.finish)
        begin
            count_reg       <= err_reg ? 30'd0 : add_mod(run0_reg, run1_reg);
            range_error_reg <= err_reg;
        end
    end

    // Control counters and flags.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            err_reg      <= 1'b0;
            rounds_reg   <= 13'd0;
            idx_reg      <= '0;
            rd_valid_reg <= 1'b0;
            rd_first_reg <= 1'b0;
        end
        else
        begin
            rd_valid_reg <= rd_en;
            rd_first_reg <= rd_en && (idx_reg == '0);
            if (cmd.load)
            begin
                err_reg    <= req_err;
                rounds_reg <= (array_length > 13'd1) ? (array_length - 13'd1) : 13'd0;
            end
            else if (cmd.dec_round)
            begin
                rounds_reg <= rounds_reg - 13'd1;
            end
            if (cmd.issue)
            begin
                idx_reg <= sts.last ? '0 : (idx_reg + AW'(1));
            end
        end
    end

endmodule

// ----- rtl/zigzag_array_count.sv -----
// Top level of the zig-zag array counter: controller plus datapath.
// Depends on zac_pkg, zac_ctrl and zac_datapath.
//
// Usage: a request transaction on the input channel (in_valid/in_ready) carries
// array_length n and the value range range_low..range_high. One result
// transaction on the output channel (out_valid/out_ready) returns count, the
// number of length-n arrays over that range whose neighbors alternate strictly
// up and down, modulo 1000000007, and range_error.
// With m = range_high - range_low + 1, a request is loaded, fills the tables,
// runs two sweeps (sum and update) per round for n-1 rounds (no rounds for n
// below two), and then totals. Each sweep touches one table entry per cycle
// through the single read and write port of each table. A request with
// range_low > range_high or with m above MAX_RANGE returns count 0 and
// range_error 1.
// One request is in flight at a time; in_ready is high only while idle.
// The result sits in an output register, so a new request is taken while a
// previous result waits; a stalled receiver holds the block at the end of
// that next request until the register frees. Reset clears the controller;
// the tables need no clearing, each request fills what it uses.
module zigzag_array_count
    import zac_pkg::*;
#(
    parameter int unsigned MAX_RANGE = 2048
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [12:0] array_length,
    input  logic [15:0] range_low,
    input  logic [15:0] range_high,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [29:0] count,
    output logic        range_error
);

    cmd_t cmd;
    sts_t sts;

    // Sequencer.
    zac_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd),
        .sts       (sts)
    );

    // Tables and arithmetic.
    zac_datapath #(
        .MAX_RANGE (MAX_RANGE)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .array_length (array_length),
        .range_low    (range_low),
        .range_high   (range_high),
        .cmd          (cmd),
        .sts          (sts),
        .count        (count),
        .range_error  (range_error)
    );

endmodule

// ----- rtl/zac_checker.sv -----
// Port checker for the zig-zag array counter, bound to the top level.
// Depends on zac_pkg and the macros in zigzag_array_count_assert.svh.
`include "zigzag_array_count_assert.svh"

module zac_checker
    import zac_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [29:0] count,
    input logic        range_error
);

    // A stalled result holds its value.
    `ZAC_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(count) && $stable(range_error))

    // An error result always carries a zero count.
    `ZAC_ASSERT_SAME(a_err_zero, clk, rst_n, out_valid && range_error, count == 30'd0)

    // Every count is a reduced residue.
    `ZAC_ASSERT_SAME(a_count_range, clk, rst_n, out_valid, count < ZAC_PRIME)

    // Only one request is worked on at a time.
    `ZAC_ASSERT_NEXT(a_one_busy, clk, rst_n, in_valid && in_ready, !in_ready)

endmodule

bind zigzag_array_count zac_checker u_zac_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .count       (count),
    .range_error (range_error)
);
